// ----- rtl/floppy_controller_register_front_macros.svh -----
// ----------------------------------------------------------------------------
// Diskette controller register front - assertion macros
// Concurrent check wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_CONTROLLER_REGISTER_FRONT_MACROS_SVH
`define FLOPPY_CONTROLLER_REGISTER_FRONT_MACROS_SVH

`ifndef NO_ASSERTIONS
// check a property outside of reset
`define FLPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check a property at every edge, reset included
`define FLPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FLPC_ASSERT(lbl, prop, msg)
`define FLPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/flpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Diskette controller register front - package
// Port access codes, command codes, error bits and the command result type.
// ----------------------------------------------------------------------------
`default_nettype none

package flpc_pkg;

    localparam int TRACKS_DEF       = 77;
    localparam int SECTORS_DEF      = 52;
    localparam int SECTOR_BYTES_DEF = 128;

    localparam int OFFSET_W = 19;

    typedef enum logic [2:0] {
        OPC_STATUS    = 3'd0,
        OPC_RTYPE     = 3'd1,
        OPC_RBYTE     = 3'd2,
        OPC_ADDR_LOW  = 3'd3,
        OPC_ADDR_HIGH = 3'd4,
        OPC_RESET     = 3'd5,
        OPC_MEDIA     = 3'd6
    } t_opcode;

    // instruction byte operations
    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_SEEK    = 3'd1;
    localparam logic [2:0] OP_FORMAT  = 3'd2;
    localparam logic [2:0] OP_RECAL   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_VERIFY  = 3'd5;
    localparam logic [2:0] OP_WRITE   = 3'd6;
    localparam logic [2:0] OP_WRITE_D = 3'd7;

    // medium states
    localparam logic [2:0] MED_WRITABLE  = 3'd0;
    localparam logic [2:0] MED_READ_ONLY = 3'd1;
    localparam logic [2:0] MED_ABSENT_OK = 3'd2;
    localparam logic [2:0] MED_ABSENT_NO = 3'd3;
    localparam logic [2:0] MED_BAD_SIZE  = 3'd4;

    // data mover outcomes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_SEEK  = 2'd1;
    localparam logic [1:0] FLT_SHORT = 2'd2;

    // result error bits
    localparam logic [7:0] ERR_NONE      = 8'h00;
    localparam logic [7:0] ERR_SEEK      = 8'h04;
    localparam logic [7:0] ERR_ADDRESS   = 8'h08;
    localparam logic [7:0] ERR_SHORT     = 8'h10;
    localparam logic [7:0] ERR_PROTECT   = 8'h20;
    localparam logic [7:0] ERR_NOT_READY = 8'h80;

    // status byte fixed bits and result type code
    localparam logic [7:0] STAT_PRESENT = 8'h08;
    localparam logic [7:0] STAT_DDEN    = 8'h10;
    localparam logic [7:0] RTYPE_STATUS = 8'h02;
    localparam logic [7:0] RTYPE_ERROR  = 8'h00;

    typedef struct packed {
        logic [7:0]          err;
        logic                go;
        logic [OFFSET_W-1:0] offset;
    } t_cmd_result;

endpackage

`default_nettype wire

// ----- rtl/flpc_cmd_check.sv -----
// ----------------------------------------------------------------------------
// Diskette controller register front - command checker
// Validates one parameter block and forms error bits, start and image offset.
// ----------------------------------------------------------------------------
`default_nettype none

module flpc_cmd_check
    import flpc_pkg::*;
#(
    parameter int TRACKS       = TRACKS_DEF,
    parameter int SECTORS      = SECTORS_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  wire logic [3:0]  i_unit_ready,
    input  wire logic [7:0]  i_instruction,
    input  wire logic [7:0]  i_count,
    input  wire logic [7:0]  i_track,
    input  wire logic [7:0]  i_sector,
    input  wire logic [2:0]  i_medium,
    input  wire logic [1:0]  i_fault,
    input  wire logic [15:0] i_track_base,
    output t_cmd_result      o_result
);

    localparam logic [7:0] TRACKS_B  = 8'(TRACKS);
    localparam logic [7:0] SECTORS_B = 8'(SECTORS);
    localparam int         SB_W      = $clog2(SECTOR_BYTES + 1);
    localparam int         FULL_W    = 17 + SB_W;

    logic [2:0]        op;
    logic [1:0]        unit;
    logic              bad_range;
    logic [8:0]        sec_end;
    logic [16:0]       sec_index;
    logic [FULL_W-1:0] full_offset;
    logic [7:0]        err;
    logic              go;

    assign op   = i_instruction[2:0];
    assign unit = i_instruction[5:4];

    // last sector plus one, compared against one past the track end
    assign sec_end   = {1'b0, i_sector} + {1'b0, i_count};
    assign bad_range = (i_track >= TRACKS_B) || (i_sector == 8'd0) ||
                       (i_sector > SECTORS_B) || (i_count > SECTORS_B) ||
                       (sec_end > ({1'b0, SECTORS_B} + 9'd1));

    // format starts at sector one of the track
    assign sec_index   = {1'b0, i_track_base} +
                         ((op == OP_FORMAT) ? 17'd0 : {9'd0, i_sector - 8'd1});
    assign full_offset = FULL_W'(sec_index) * FULL_W'(SECTOR_BYTES);

    always_comb begin
        err = ERR_NONE;
        go  = 1'b0;
        if (!i_unit_ready[unit]) begin
            err = ERR_NOT_READY;
        end else begin
            case (op)
                OP_SEEK: begin
                    if (i_track >= TRACKS_B) err = ERR_ADDRESS;
                end
                OP_FORMAT: begin
                    if (i_track >= TRACKS_B) begin
                        err = ERR_ADDRESS;
                    end else if (i_medium > MED_BAD_SIZE || i_medium == MED_ABSENT_NO ||
                                 (i_medium == MED_READ_ONLY && i_track != 8'd0)) begin
                        err = ERR_NOT_READY;
                    end else begin
                        go = 1'b1;
                    end
                end
                OP_READ, OP_VERIFY: begin
                    if (bad_range) begin
                        err = ERR_ADDRESS;
                    end else if (i_medium >= MED_ABSENT_OK) begin
                        err = ERR_NOT_READY;
                    end else begin
                        go = 1'b1;
                    end
                end
                OP_WRITE, OP_WRITE_D: begin
                    if (bad_range) begin
                        err = ERR_ADDRESS;
                    end else if (i_medium == MED_READ_ONLY) begin
                        err = ERR_PROTECT;
                    end else if (i_medium != MED_WRITABLE) begin
                        err = ERR_NOT_READY;
                    end else begin
                        go = 1'b1;
                    end
                end
                default: begin
                    err = ERR_NONE;
                end
            endcase
        end
        // data mover outcome overrides once the transfer is under way
        if (go) begin
            if (i_fault == FLT_SEEK) begin
                err = ERR_SEEK;
            end else if (i_fault == FLT_SHORT) begin
                err = ERR_SHORT;
            end
        end
    end

    assign o_result.err    = err;
    assign o_result.go     = go;
    assign o_result.offset = go ? full_offset[OFFSET_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/floppy_controller_register_front.sv -----
// ----------------------------------------------------------------------------
// Diskette controller register front - top level
// Port access decoder with command checks, one item per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//
//  channel  dir  width        contents
//  -------  ---  -----------  -------------------------------------------
//  s_axis   in   64 + 3 user  one port access or event with its block
//  m_axis   out  48           read byte, interrupt, start, offset, address
//
//  One item per cycle sustained while the receiver takes each result. An
//  accepted item is held in the input register and moves to the result
//  register when that register is free or being drained. Controller state
//  updates at the same edge the result is registered, so the next item sees
//  it with no bubble. Reset (synchronous, active low) empties both stages
//  and loads the power-up controller state. A stalled result holds in the
//  output register while one more item waits in the input register.
//
`default_nettype none

module floppy_controller_register_front
    import flpc_pkg::*;
#(
    parameter int TRACKS       = TRACKS_DEF,
    parameter int SECTORS      = SECTORS_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // write_byte[7:0] units_present[11:8] channel_word[19:12]
    // instruction_byte[27:20] sector_count[35:28] track_number[43:36]
    // sector_number[51:44] medium_state[54:52] transfer_fault[56:55] zero[63:57]
    input  wire logic [63:0] s_axis_tdata,
    // opcode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0] interrupt_line[8] start_transfer[9] image_offset[28:10]
    // block_address[44:29] zero[47:45]
    output logic [47:0]      m_axis_tdata
);

    `include "floppy_controller_register_front_macros.svh"

    localparam logic [7:0] SECTORS_B = 8'(SECTORS);

    // pipeline control
    logic        r_in_valid;
    logic        r_out_valid;
    logic        w_advance;
    logic        w_fire;

    // input stage payload
    t_opcode     r_opcode;
    logic [7:0]  r_wbyte;
    logic [3:0]  r_units;
    logic [7:0]  r_chan;
    logic [7:0]  r_instr;
    logic [7:0]  r_count;
    logic [7:0]  r_track;
    logic [7:0]  r_sector;
    logic [2:0]  r_medium;
    logic [1:0]  r_fault;
    logic [15:0] r_track_base;
    logic [15:0] n_track_base;

    // controller state
    logic [3:0]  r_unit_ready, n_unit_ready;
    logic        r_irq, n_irq;
    logic        r_rstat, n_rstat;
    logic [7:0]  r_err, n_err;
    logic [15:0] r_addr, n_addr;

    // result register
    logic [47:0] r_out_data;
    logic [7:0]  w_rdata;
    logic        w_start;
    logic [OFFSET_W-1:0] w_offset;

    t_cmd_result w_cmd;

    // the stage advances whenever the result slot is free or being drained
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // track times sectors, formed at capture to keep one multiply per stage
    assign n_track_base = {8'd0, s_axis_tdata[43:36]} * {8'd0, SECTORS_B};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // capture an item into the input stage
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_opcode     <= t_opcode'(s_axis_tuser);
            r_wbyte      <= s_axis_tdata[7:0];
            r_units      <= s_axis_tdata[11:8];
            r_chan       <= s_axis_tdata[19:12];
            r_instr      <= s_axis_tdata[27:20];
            r_count      <= s_axis_tdata[35:28];
            r_track      <= s_axis_tdata[43:36];
            r_sector     <= s_axis_tdata[51:44];
            r_medium     <= s_axis_tdata[54:52];
            r_fault      <= s_axis_tdata[56:55];
            r_track_base <= n_track_base;
        end
    end

    flpc_cmd_check #(
        .TRACKS       (TRACKS),
        .SECTORS      (SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_cmd_check (
        .i_unit_ready  (r_unit_ready),
        .i_instruction (r_instr),
        .i_count       (r_count),
        .i_track       (r_track),
        .i_sector      (r_sector),
        .i_medium      (r_medium),
        .i_fault       (r_fault),
        .i_track_base  (r_track_base),
        .o_result      (w_cmd)
    );

    // decode the access against the current controller state
    always_comb begin
        n_unit_ready = r_unit_ready;
        n_irq        = r_irq;
        n_rstat      = r_rstat;
        n_err        = r_err;
        n_addr       = r_addr;
        w_rdata      = 8'd0;
        w_start      = 1'b0;
        w_offset     = '0;
        case (r_opcode)
            OPC_STATUS: begin
                w_rdata = STAT_PRESENT | STAT_DDEN |
                          {1'b0, r_unit_ready[3], r_unit_ready[2], 2'b00,
                           r_irq, r_unit_ready[1], r_unit_ready[0]};
            end
            OPC_RTYPE: begin
                // reading the result type acknowledges the interrupt
                n_irq   = 1'b0;
                w_rdata = r_rstat ? RTYPE_STATUS : RTYPE_ERROR;
            end
            OPC_RBYTE: begin
                if (r_rstat) begin
                    w_rdata = {r_unit_ready[1], r_unit_ready[0],
                               r_unit_ready[3], r_unit_ready[2], 4'b0000};
                end else begin
                    // error bits are returned once
                    w_rdata = r_err;
                    n_rstat = 1'b1;
                end
            end
            OPC_ADDR_LOW: begin
                n_addr = {8'd0, r_wbyte};
            end
            OPC_ADDR_HIGH: begin
                n_addr   = r_addr | {r_wbyte, 8'd0};
                n_rstat  = 1'b0;
                n_err    = w_cmd.err;
                w_start  = w_cmd.go;
                w_offset = w_cmd.offset;
                if (r_chan[5:4] == 2'b00) begin
                    n_irq = 1'b1;
                end
            end
            OPC_RESET: begin
                n_unit_ready = r_units;
                n_rstat      = 1'b1;
                n_err        = ERR_NONE;
                n_irq        = 1'b0;
            end
            OPC_MEDIA: begin
                // ignore while an error result is still unread
                if (r_rstat && (r_unit_ready != r_units)) begin
                    n_unit_ready = r_units;
                    n_irq        = 1'b1;
                end
            end
            default: begin
                w_rdata = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ready <= 4'd0;
            r_irq        <= 1'b0;
            r_rstat      <= 1'b1;
            r_err        <= ERR_NONE;
            r_addr       <= 16'd0;
        end else if (w_fire) begin
            r_unit_ready <= n_unit_ready;
            r_irq        <= n_irq;
            r_rstat      <= n_rstat;
            r_err        <= n_err;
            r_addr       <= n_addr;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {3'b000, n_addr, w_offset, w_start, n_irq, w_rdata};
        end
    end

    `FLPC_ASSERT_ALWAYS(a_reset_flush, !i_rst_n |=> !r_in_valid && !r_out_valid, "stages not empty after reset")
    `FLPC_ASSERT(a_hold_item, r_in_valid && !w_advance |=> r_in_valid, "waiting item dropped")
    `FLPC_ASSERT(a_cmd_result, w_fire && r_opcode == OPC_ADDR_HIGH |=> !r_rstat, "command left ready status")
    `FLPC_ASSERT(a_irq_ack, w_fire && r_opcode == OPC_RTYPE |=> !r_irq, "interrupt not acknowledged")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diskette controller register front - testbench
// Sends port accesses and commands on the input stream and predicts every
// result. Compares each result field with the prediction under sender gaps
// and receiver backpressure.
// ----------------------------------------------------------------------------

module tb_top;
    import flpc_pkg::*;

    // opcode with no function: it must leave the controller state alone
    localparam logic [2:0] OPC_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 440;
    localparam int MAX_REPORTS = 50;

    // one port access or event as carried on the input stream
    typedef struct {
        logic [2:0] opcode;
        logic [7:0] write_byte;
        logic [3:0] units;
        logic [7:0] channel;
        logic [7:0] instr;
        logic [7:0] count;
        logic [7:0] track;
        logic [7:0] sector;
        logic [2:0] med_state;
        logic [1:0] fault;
    } t_access;

    // one result item as carried on the output stream
    typedef struct {
        logic [7:0]          read_data;
        logic                irq;
        logic                start;
        logic [OFFSET_W-1:0] offset;
        logic [15:0]         blk_addr;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // write_byte[7:0] units_present[11:8] channel_word[19:12]
    // instruction_byte[27:20] sector_count[35:28] track_number[43:36]
    // sector_number[51:44] medium_state[54:52] transfer_fault[56:55] zero[63:57]
    logic [63:0] s_axis_tdata = '0;
    // opcode[2:0]
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_data[7:0] interrupt_line[8] start_transfer[9] image_offset[28:10]
    // block_address[44:29] zero[47:45]
    logic [47:0] m_axis_tdata;

    // controller state as the predictor sees it, at its power-up values
    logic [3:0]  ready_units = 4'h0;
    logic        irq_pending = 1'b0;
    logic        shows_ready = 1'b1;
    logic [7:0]  latched_err = ERR_NONE;
    logic [15:0] pb_addr = 16'h0000;

    t_outcome pending_results[$];
    t_outcome want;

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_starts = 0;
    int n_irq = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    floppy_controller_register_front dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Work out the result of one accepted item and advance the predicted
    // controller state.
    function automatic t_outcome predict_access(input t_access a);
        t_outcome   r;
        logic [2:0] op;
        logic [1:0] unit;
        logic [7:0] err;
        logic       go;
        int         pos;
        r = '{default: '0};
        op = a.instr[2:0];
        unit = a.instr[5:4];
        err = ERR_NONE;
        go = 1'b0;
        pos = 0;
        case (a.opcode)
            OPC_STATUS: begin
                r.read_data = STAT_PRESENT | STAT_DDEN |
                    {1'b0, ready_units[3], ready_units[2], 2'b00,
                     irq_pending, ready_units[1], ready_units[0]};
            end
            OPC_RTYPE: begin
                irq_pending = 1'b0;
                r.read_data = shows_ready ? RTYPE_STATUS : RTYPE_ERROR;
            end
            OPC_RBYTE: begin
                // error byte once, then the remapped ready bits
                if (shows_ready) begin
                    r.read_data = {ready_units[1], ready_units[0],
                                   ready_units[3], ready_units[2], 4'h0};
                end else begin
                    r.read_data = latched_err;
                    shows_ready = 1'b1;
                end
            end
            OPC_ADDR_LOW: begin
                pb_addr = {8'h00, a.write_byte};
            end
            OPC_ADDR_HIGH: begin
                pb_addr[15:8] = pb_addr[15:8] | a.write_byte;
                shows_ready = 1'b0;
                if (!ready_units[unit]) begin
                    err = ERR_NOT_READY;
                end else if (op == OP_SEEK) begin
                    if (a.track >= TRACKS_DEF) err = ERR_ADDRESS;
                end else if (op == OP_FORMAT) begin
                    // a read-only medium may only be recreated from track zero
                    if (a.track >= TRACKS_DEF) begin
                        err = ERR_ADDRESS;
                    end else if (a.med_state > MED_BAD_SIZE ||
                                 a.med_state == MED_ABSENT_NO ||
                                 (a.med_state == MED_READ_ONLY && a.track != 0)) begin
                        err = ERR_NOT_READY;
                    end else begin
                        go = 1'b1;
                        pos = int'(a.track) * SECTORS_DEF * SECTOR_BYTES_DEF;
                    end
                end else if (op >= OP_READ) begin
                    if (a.track >= TRACKS_DEF || a.sector == 0 || a.sector > SECTORS_DEF ||
                        a.count > SECTORS_DEF ||
                        int'(a.sector) + int'(a.count) - 1 > SECTORS_DEF) begin
                        err = ERR_ADDRESS;
                    end else if (op <= OP_VERIFY) begin
                        if (a.med_state >= MED_ABSENT_OK) err = ERR_NOT_READY;
                        else go = 1'b1;
                    end else if (a.med_state == MED_READ_ONLY) begin
                        err = ERR_PROTECT;
                    end else if (a.med_state != MED_WRITABLE) begin
                        err = ERR_NOT_READY;
                    end else begin
                        go = 1'b1;
                    end
                    if (go) begin
                        pos = (int'(a.track) * SECTORS_DEF + int'(a.sector) - 1) *
                              SECTOR_BYTES_DEF;
                    end
                end
                if (go) begin
                    if (a.fault == FLT_SEEK) err = ERR_SEEK;
                    else if (a.fault == FLT_SHORT) err = ERR_SHORT;
                end
                latched_err = err;
                if (a.channel[5:4] == 2'b00) irq_pending = 1'b1;
                r.start = go;
                r.offset = go ? pos[OFFSET_W-1:0] : '0;
            end
            OPC_RESET: begin
                ready_units = a.units;
                shows_ready = 1'b1;
                latched_err = ERR_NONE;
                irq_pending = 1'b0;
            end
            OPC_MEDIA: begin
                // ignored while an error byte waits to be read
                if (shows_ready && ready_units != a.units) begin
                    ready_units = a.units;
                    irq_pending = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.irq = irq_pending;
        r.blk_addr = pb_addr;
        return r;
    endfunction

    // Present one item, hold it until accepted, then queue its prediction.
    task automatic send_item(input t_access a);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, a.fault, a.med_state, a.sector, a.track, a.count,
                         a.instr, a.channel, a.units, a.write_byte};
        s_axis_tuser <= a.opcode;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_access(a));
        n_sent++;
    endtask

    function automatic t_access port_access(input logic [2:0] opc,
                                            input logic [7:0] wb,
                                            input logic [3:0] units);
        t_access a;
        a = '{default: '0};
        a.opcode = opc;
        a.write_byte = wb;
        a.units = units;
        return a;
    endfunction

    // address high write that runs one command
    function automatic t_access cmd(input logic [2:0] op, input logic [1:0] unit,
                                    input logic [7:0] chan, input logic [7:0] count,
                                    input logic [7:0] track, input logic [7:0] sector,
                                    input logic [2:0] med, input logic [1:0] fault);
        t_access a;
        a = '{default: '0};
        a.opcode = OPC_ADDR_HIGH;
        a.write_byte = 8'($urandom_range(255));
        a.channel = chan;
        a.instr = {2'($urandom_range(3)), unit, 1'($urandom_range(1)), op};
        a.count = count;
        a.track = track;
        a.sector = sector;
        a.med_state = med;
        a.fault = fault;
        return a;
    endfunction

    function automatic t_access rand_access();
        t_access a;
        a.opcode = 3'($urandom_range(7));
        a.write_byte = 8'($urandom_range(255));
        a.units = 4'($urandom_range(15));
        a.channel = 8'($urandom_range(255));
        a.instr = 8'($urandom_range(255));
        a.count = 8'($urandom_range(255));
        a.track = 8'($urandom_range(255));
        a.sector = 8'($urandom_range(255));
        a.med_state = 3'($urandom_range(7));
        a.fault = 2'($urandom_range(3));
        return a;
    endfunction

    // mostly in-range commands on usable media, so that transfers start
    function automatic t_access rand_command();
        t_access a;
        a = rand_access();
        a.opcode = OPC_ADDR_HIGH;
        if ($urandom_range(1) == 0) a.channel[5:4] = 2'b00;
        if ($urandom_range(9) < 8) begin
            a.track = 8'($urandom_range(TRACKS_DEF - 1));
            a.sector = 8'($urandom_range(SECTORS_DEF, 1));
            a.count = 8'($urandom_range(SECTORS_DEF + 1 - int'(a.sector)));
        end
        if ($urandom_range(9) < 7) a.med_state = 3'($urandom_range(MED_READ_ONLY));
        if ($urandom_range(3) != 0) a.fault = FLT_NONE;
        return a;
    endfunction

    // The usual host sequence: optional reset or media check, address low,
    // address high with the command, then the result reads. Steps drop out
    // at random to give broken sequences too.
    task automatic run_session();
        t_access a;
        a = rand_access();
        if ($urandom_range(9) == 0) begin
            a.opcode = OPC_RESET;
            if ($urandom_range(9) < 6) a.units = 4'hF;
            send_item(a);
        end else if ($urandom_range(7) == 0) begin
            a.opcode = OPC_MEDIA;
            if ($urandom_range(1) == 0) a.units = 4'hF;
            send_item(a);
        end
        if ($urandom_range(9) != 0) begin
            a = rand_access();
            a.opcode = OPC_ADDR_LOW;
            send_item(a);
        end
        send_item(rand_command());
        if ($urandom_range(3) != 0) begin
            a = rand_access();
            a.opcode = OPC_RTYPE;
            send_item(a);
        end
        if ($urandom_range(5) != 0) begin
            a = rand_access();
            a.opcode = OPC_RBYTE;
            send_item(a);
        end
        if ($urandom_range(3) == 0) begin
            a = rand_access();
            a.opcode = $urandom_range(1) ? OPC_STATUS : OPC_RBYTE;
            send_item(a);
        end
    endtask

    task automatic test_port_reads();
        send_item(port_access(OPC_STATUS, 8'h00, 4'h0));
        send_item(port_access(OPC_RBYTE, 8'h00, 4'h0));
        send_item(port_access(OPC_UNUSED, 8'hFF, 4'hF));
    endtask

    task automatic test_reset_and_media();
        send_item(port_access(OPC_RESET, 8'h00, 4'hF));
        send_item(port_access(OPC_RBYTE, 8'h00, 4'h0));
        send_item(port_access(OPC_MEDIA, 8'h00, 4'hF));
        send_item(port_access(OPC_MEDIA, 8'h00, 4'b0101));
        send_item(port_access(OPC_RTYPE, 8'h00, 4'h0));
    endtask

    task automatic test_address_writes();
        send_item(port_access(OPC_ADDR_LOW, 8'hFF, 4'h0));
        send_item(cmd(OP_NOP, 2'd0, 8'h30, 8'h00, 8'h00, 8'h00, MED_WRITABLE, FLT_NONE));
        send_item(port_access(OPC_ADDR_LOW, 8'h00, 4'h0));
    endtask

    task automatic test_command_checks();
        send_item(port_access(OPC_RESET, 8'h00, 4'b1110));
        // unit zero absent
        send_item(cmd(OP_READ, 2'd0, 8'h00, 8'd1, 8'd0, 8'd1, MED_WRITABLE, FLT_NONE));
        // media check while the error byte is unread
        send_item(port_access(OPC_MEDIA, 8'h00, 4'b0001));
        send_item(port_access(OPC_RBYTE, 8'h00, 4'h0));
        // last sector of last track: largest offset
        send_item(cmd(OP_READ, 2'd1, 8'h40, 8'd1, 8'd76, 8'd52, MED_WRITABLE, FLT_NONE));
        send_item(cmd(OP_WRITE, 2'd2, 8'h10, 8'd1, 8'd10, 8'd5, MED_READ_ONLY, FLT_NONE));
        // read-only medium recreated by a format of track zero
        send_item(cmd(OP_FORMAT, 2'd3, 8'h00, 8'd0, 8'd0, 8'd0, MED_READ_ONLY, FLT_SEEK));
        send_item(cmd(OP_VERIFY, 2'd1, 8'h00, 8'd1, 8'd77, 8'd1, MED_WRITABLE, FLT_NONE));
        send_item(cmd(OP_READ, 2'd1, 8'h00, 8'd1, 8'd5, 8'd0, MED_WRITABLE, FLT_NONE));
        // zero count is accepted
        send_item(cmd(OP_WRITE_D, 2'd1, 8'h00, 8'd0, 8'd3, 8'd1, MED_WRITABLE, FLT_SHORT));
        send_item(cmd(OP_SEEK, 2'd2, 8'hFF, 8'd0, 8'd255, 8'd0, MED_WRITABLE, FLT_NONE));
        send_item(cmd(OP_RECAL, 2'd3, 8'h00, 8'd255, 8'd255, 8'd255, 3'd7, 2'd3));
        send_item(cmd(OP_FORMAT, 2'd1, 8'h00, 8'd0, 8'd5, 8'd0, 3'd7, FLT_NONE));
        // run of sectors past the end of the track
        send_item(cmd(OP_READ, 2'd1, 8'h00, 8'd52, 8'd10, 8'd2, MED_WRITABLE, FLT_NONE));
        send_item(port_access(OPC_RBYTE, 8'h00, 4'h0));
        send_item(port_access(OPC_RTYPE, 8'h00, 4'h0));
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            target = n_sent + ITEMS_PER_PHASE;
            while (n_sent < target) begin
                if ($urandom_range(4) == 0) send_item(rand_access());
                else run_session();
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] expected_val,
                                 input logic [31:0] actual_val);
        if (actual_val !== expected_val) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, expected_val, actual_val);
            end
        end
    endtask

    // Check each accepted result against the oldest prediction, then pick
    // the ready level for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                compare_field("read_data", 32'(want.read_data), 32'(m_axis_tdata[7:0]));
                compare_field("interrupt_line", 32'(want.irq), 32'(m_axis_tdata[8]));
                compare_field("start_transfer", 32'(want.start), 32'(m_axis_tdata[9]));
                compare_field("image_offset", 32'(want.offset), 32'(m_axis_tdata[28:10]));
                compare_field("block_address", 32'(want.blk_addr),
                              32'(m_axis_tdata[44:29]));
                n_checked++;
                if (want.start) n_starts++;
                if (want.irq) n_irq++;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_port_reads();
        test_reset_and_media();
        test_address_writes();
        test_command_checks();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d items and %0d results: %0d transfer starts, %0d with irq high",
                 n_sent, n_checked, n_starts, n_irq);
        $display("Flow phases: free running, sender gaps, receiver stalls, both mixed");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
